// ===== hw/rtl/flg_pkg.sv =====
// ----------------------------------------------------------------------------
// Flanger package
// Shared register indexes, field widths, sizes and the LFO settings bundle.
// ----------------------------------------------------------------------------
package flg_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEPTH_GAIN = 2'd0;
  localparam logic [1:0] CFG_PHASE_STEP = 2'd1;
  localparam logic [1:0] CFG_BASE_DELAY = 2'd2;

  // Reset values of the configuration registers
  localparam logic [16:0] DEPTH_GAIN_RST = 17'd65536;
  localparam logic [30:0] PHASE_STEP_RST = 31'd48696;
  localparam logic [9:0]  BASE_DELAY_RST = 10'd220;

  localparam int CfgDataW = 31;
  localparam int SampleW  = 16;

  // Delay line length and sine table size; both must stay powers of two
  localparam int DELAY_DEPTH     = 1024;
  localparam int SINE_TABLE_SIZE = 1024;

  // Settings that steer the LFO and the delay computation
  typedef struct packed {
    logic [16:0] depth_gain;
    logic [30:0] phase_step;
    logic [9:0]  base_delay;
  } lfo_cfg_t;

endpackage

// ===== hw/rtl/flg_lfo.sv =====
// ----------------------------------------------------------------------------
// Flanger LFO and tap delay sequencer
// Runs the phase accumulator, evaluates the sine polynomial on one shared
// multiplier, scales the base delay and clamps the resulting tap delay.
// ----------------------------------------------------------------------------
module flg_lfo import flg_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  lfo_cfg_t                       cfg,
  output logic                           done,
  output logic [$clog2(DELAY_DEPTH)-1:0] delay
);

  localparam int DW = $clog2(DELAY_DEPTH);
  localparam int SB = $clog2(SINE_TABLE_SIZE);
  // Phase bits below the table index
  localparam logic [29:0] LOW_MASK = 30'((64'd1 << (32 - SB)) - 64'd1);
  localparam logic [20:0] DMAX     = 21'(DELAY_DEPTH - 1);

  typedef enum logic [2:0] {
    L_IDLE, L_Z2, L_T1, L_T2, L_T3, L_SIN, L_MOD, L_PROD
  } lfo_state_t;

  lfo_state_t         state;
  logic [31:0]        phase_acc;
  logic [15:0]        z;
  logic               neg;
  logic [16:0]        g;
  logic [9:0]         bd;
  logic [15:0]        z2;
  logic [15:0]        t;
  logic signed [15:0] s;
  logic signed [18:0] coef;

  logic [1:0]         quad;
  logic [29:0]        r_q;
  logic [30:0]        r_fold;
  logic signed [18:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [36:0] mul_p;
  logic [15:0]        sh15;
  logic [15:0]        sin_mag;
  logic signed [18:0] mod;
  logic signed [19:0] coef_sum;
  logic [20:0]        quo;

  // Quantize the phase to a table entry and fold it into the first quadrant
  always_comb begin
    quad   = phase_acc[31:30];
    r_q    = phase_acc[29:0] & ~LOW_MASK;
    r_fold = quad[0] ? (31'h4000_0000 - {1'b0, r_q}) : {1'b0, r_q};
  end

  // Select operands of the shared multiplier
  always_comb begin
    unique case (state)
      L_Z2: begin
        mul_a = {3'b0, z};
        mul_b = {2'b0, z};
      end
      L_T1: begin
        mul_a = {3'b0, z2};
        mul_b = 18'sd153;
      end
      L_T2, L_T3: begin
        mul_a = {3'b0, z2};
        mul_b = {2'b0, t};
      end
      L_SIN: begin
        mul_a = {3'b0, z};
        mul_b = {2'b0, t};
      end
      L_MOD: begin
        mul_a = {{3{s[15]}}, s};
        mul_b = {1'b0, g};
      end
      L_PROD: begin
        mul_a = coef;
        mul_b = {8'b0, bd};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Shifted product views for each step
  always_comb begin
    sh15     = mul_p[30:15];
    sin_mag  = sh15[15] ? 16'h7fff : sh15;
    mod      = mul_p[33:15];
    coef_sum = 20'sd65536 - $signed({4'b0, g[16:1]}) + $signed({mod[18], mod});
    quo      = mul_p[36:16];
  end

  // Sequence one delay computation per start
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= L_IDLE;
      phase_acc <= '0;
      done      <= 1'b0;
      delay     <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (start) begin
            z         <= r_fold[30:15];
            neg       <= quad[1];
            g         <= cfg.depth_gain[16] ? DEPTH_GAIN_RST : cfg.depth_gain;
            bd        <= cfg.base_delay;
            phase_acc <= phase_acc + {1'b0, cfg.phase_step};
            state     <= L_Z2;
          end
        end
        L_Z2: begin
          z2    <= sh15;
          state <= L_T1;
        end
        L_T1: begin
          t     <= 16'd2611 - sh15;
          state <= L_T2;
        end
        L_T2: begin
          t     <= 16'd21167 - sh15;
          state <= L_T3;
        end
        L_T3: begin
          t     <= 16'd51472 - sh15;
          state <= L_SIN;
        end
        L_SIN: begin
          s     <= neg ? -$signed(sin_mag) : $signed(sin_mag);
          state <= L_MOD;
        end
        L_MOD: begin
          coef  <= coef_sum[18:0];
          state <= L_PROD;
        end
        L_PROD: begin
          // Clamp negative delays to zero and long ones to the last line index
          if (mul_p[36]) begin
            delay <= '0;
          end else if (quo > DMAX) begin
            delay <= DMAX[DW-1:0];
          end else begin
            delay <= quo[DW-1:0];
          end
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/flg_dline.sv =====
// ----------------------------------------------------------------------------
// Flanger delay line
// Circular sample memory with fill tracking; writes the new sample, reads
// the tap and forms the saturated sum.
// ----------------------------------------------------------------------------
module flg_dline import flg_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic signed [SampleW-1:0]      sample,
  input  logic [$clog2(DELAY_DEPTH)-1:0] delay,
  output logic signed [SampleW-1:0]      sum
);

  localparam int DW = $clog2(DELAY_DEPTH);
  localparam logic [DW-1:0] FILL_MAX = DW'(DELAY_DEPTH - 1);

  logic signed [SampleW-1:0] mem [DELAY_DEPTH];
  logic signed [SampleW-1:0] rd_data;
  logic signed [SampleW-1:0] x_q;
  logic                      tap_en;
  logic                      fwd;
  logic [DW-1:0]             write_pos;
  logic [DW-1:0]             fill_count;
  logic [DW-1:0]             rd_idx;
  logic signed [SampleW-1:0] tap;
  logic signed [SampleW:0]   total;

  assign rd_idx = write_pos - delay;

  // Write the new sample and read the tap in the same cycle
  always_ff @(posedge clk) begin
    if (go) begin
      mem[write_pos] <= sample;
      rd_data        <= mem[rd_idx];
    end
  end

  // Hold the request and the tap decision for the sum cycle
  always_ff @(posedge clk) begin
    if (go) begin
      x_q    <= sample;
      tap_en <= (fill_count >= delay);
      fwd    <= (delay == '0);
    end
  end

  // Advance the write pointer and the saturating fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos  <= '0;
      fill_count <= '0;
    end else if (go) begin
      write_pos <= write_pos + 1'b1;
      if (fill_count != FILL_MAX) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  // Forward the current sample on zero delay, then add and saturate
  always_comb begin
    tap   = fwd ? x_q : rd_data;
    total = $signed({x_q[SampleW-1], x_q}) +
            (tap_en ? $signed({tap[SampleW-1], tap}) : $signed((SampleW + 1)'(0)));
    if (total[SampleW] != total[SampleW-1]) begin
      sum = total[SampleW] ? {1'b1, {(SampleW - 1){1'b0}}} : {1'b0, {(SampleW - 1){1'b1}}};
    end else begin
      sum = total[SampleW-1:0];
    end
  end

endmodule

// ===== hw/rtl/sine_lfo_flanger_unit.sv =====
// Sequence per request: the accept cycle, seven steps of the shared LFO multiplier,
//   the delay-line write/read, the sum cycle and the output load; no new request is
//   taken before that output load, since in_stall is high outside the idle state.
// A new request is taken while a finished result still waits in the output register.
// Reset (rst, synchronous, active high) clears phase, write pointer, fill count and
//   the registers to their defaults; the delay memory is not cleared.
// ----------------------------------------------------------------------------
// Sine LFO flanger
// Top level: request handshake, configuration registers and sequencing of the
// LFO and the delay line.
// ----------------------------------------------------------------------------
module sine_lfo_flanger_unit import flg_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [CfgDataW-1:0]        cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SampleW-1:0]  sample_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SampleW-1:0]  sample_out
);

  localparam int DW = $clog2(DELAY_DEPTH);

  typedef enum logic [1:0] {T_IDLE, T_LFO, T_RD, T_OUT} top_state_t;

  top_state_t                state;
  lfo_cfg_t                  cfg;
  logic signed [SampleW-1:0] x_hold;
  logic                      accept;
  logic                      lfo_done;
  logic [DW-1:0]             delay;
  logic                      go;
  logic                      load;
  logic signed [SampleW-1:0] sum;

  assign in_stall = (state != T_IDLE);
  assign accept   = in_valid && !in_stall;
  assign go       = (state == T_LFO) && lfo_done;
  assign load     = (state == T_OUT) && (!out_valid || !out_stall);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_gain <= DEPTH_GAIN_RST;
      cfg.phase_step <= PHASE_STEP_RST;
      cfg.base_delay <= BASE_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEPTH_GAIN: cfg.depth_gain <= cfg_data[16:0];
        CFG_PHASE_STEP: cfg.phase_step <= cfg_data;
        CFG_BASE_DELAY: cfg.base_delay <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Request sequencing and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Load a finished sum, or drop a result once it is taken
      if (load) begin
        sample_out <= sum;
        out_valid  <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            x_hold <= sample_in;
            state  <= T_LFO;
          end
        end
        T_LFO: begin
          if (lfo_done) begin
            state <= T_RD;
          end
        end
        T_RD: state <= T_OUT;
        T_OUT: begin
          if (load) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  flg_lfo u_lfo (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .cfg   (cfg),
    .done  (lfo_done),
    .delay (delay)
  );

  flg_dline u_dline (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .sample (x_hold),
    .delay  (delay),
    .sum    (sum)
  );

  // The LFO only finishes while a request waits for it
  a_done_in_lfo: assert property (@(posedge clk) disable iff (rst)
    lfo_done |-> (state == T_LFO))
    else $error("LFO finished outside of a request");

  // An accepted request blocks further requests on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("request taken while busy");

  // A load always leaves a valid result behind
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("loaded result not presented");

  // The delay line is written once per request
  a_single_go: assert property (@(posedge clk) disable iff (rst)
    go |=> !go)
    else $error("delay line written twice for one request");

endmodule
